[src/key_value_map_table_macros.svh]
// Assertion macros for the key-value map table
`ifndef KEY_VALUE_MAP_TABLE_MACROS_SVH
`define KEY_VALUE_MAP_TABLE_MACROS_SVH

// same-cycle implication
`define KVMT_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("key_value_map_table: check failed");

// next-cycle implication
`define KVMT_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("key_value_map_table: check failed");

`endif

[src/kvmt_pkg.sv]
// Shared types and constants of the key-value map table
package kvmt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int ENTRY_W       = 7;
  localparam int DATA_W        = 32;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     found;
    logic                     full_res;
    logic [ENTRY_W-1:0]       entry_total;
    logic                     empty_res;
  } rsp_t;

  // request walking down the cell chain, collecting match and free slot
  typedef struct packed {
    logic                     active;
    logic [1:0]               func;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
    logic                     hit;
    logic [IDX_W-1:0]         hit_idx;
    logic signed [DATA_W-1:0] hit_value;
    logic                     free_ok;
    logic [IDX_W-1:0]         free_idx;
  } pkt_t;

  // update broadcast to all cells at the end of a walk
  typedef struct packed {
    logic                     en;
    logic                     clr;
    logic                     set_key;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } commit_t;

endpackage

[src/key_value_map_table.sv]
// Top level of the key-value map table: cell chain, control and result register
//
// Fixed-capacity key-value map of kvmt_pkg::TABLE_ENTRIES slots with fully
// associative lookup. One item is handled at a time: an accepted request walks
// down a chain of slot cells, one cell per cycle, gathering the matching slot
// and the lowest free slot, then a single update is applied to the chosen
// cell and the result is registered, once the previous result has been taken.
// The next item is accepted the cycle after the result is registered, even
// while that result still waits to be taken; a new item is never accepted
// before the walk of the last one is through.
module key_value_map_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  kvmt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output kvmt_pkg::rsp_t rsp
);

  `include "key_value_map_table_macros.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t                           state;
  kvmt_pkg::pkt_t                   chain [kvmt_pkg::TABLE_ENTRIES+1];
  kvmt_pkg::pkt_t                   held;
  kvmt_pkg::commit_t                commit;
  kvmt_pkg::rsp_t                   rsp_next;
  logic [kvmt_pkg::CNT_W-1:0]       count;
  logic [kvmt_pkg::CNT_W-1:0]       count_next;
  logic                             load;
  logic                             walk_done;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    chain[0]           = '0;
    chain[0].active    = req_valid && req_ready;
    chain[0].func      = req.func;
    chain[0].key       = req.key;
    chain[0].value     = req.value;
  end

  for (genvar i = 0; i < kvmt_pkg::TABLE_ENTRIES; i++) begin : g_cell
    kvmt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .slot_idx (kvmt_pkg::IDX_W'(i)),
      .pkt_in   (chain[i]),
      .commit   (commit),
      .pkt_out  (chain[i+1])
    );
  end

  assign walk_done = chain[kvmt_pkg::TABLE_ENTRIES].active;
  assign load      = (state == ST_DONE) && (!rsp_valid || rsp_ready);

  always_comb begin
    commit               = '0;
    commit.key           = held.key;
    commit.value         = held.value;
    count_next           = count;
    rsp_next             = '0;
    if (held.hit) begin
      rsp_next.found        = 1'b1;
      rsp_next.result_value = held.hit_value;
      commit.idx            = held.hit_idx;
      case (held.func)
        kvmt_pkg::FUNC_INSERT: begin
          commit.en = load;
        end
        kvmt_pkg::FUNC_REMOVE: begin
          commit.en  = load;
          commit.clr = 1'b1;
          if (count != '0) begin
            count_next = count - kvmt_pkg::CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end else if (held.func == kvmt_pkg::FUNC_INSERT) begin
      if (held.free_ok && (count < kvmt_pkg::CNT_FULL)) begin
        commit.en      = load;
        commit.set_key = 1'b1;
        commit.idx     = held.free_idx;
        count_next     = count + kvmt_pkg::CNT_W'(1);
      end else begin
        rsp_next.full_res = 1'b1;
      end
    end
    rsp_next.entry_total = kvmt_pkg::ENTRY_W'(count_next);
    rsp_next.empty_res   = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (rsp_valid && rsp_ready && !load) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (walk_done) begin
            held  <= chain[kvmt_pkg::TABLE_ENTRIES];
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load) begin
            rsp       <= rsp_next;
            rsp_valid <= 1'b1;
            count     <= count_next;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `KVMT_ASSERT_NOW(a_walk_ends_in_scan, clk, rst, walk_done, state == ST_SCAN)
  `KVMT_ASSERT_NEXT(a_one_item_at_a_time, clk, rst, req_valid && req_ready, !req_ready)
  `KVMT_ASSERT_NOW(a_count_in_range, clk, rst, 1'b1, count <= kvmt_pkg::CNT_FULL)
  `KVMT_ASSERT_NOW(a_full_only_on_miss, clk, rst, rsp_valid && rsp.full_res, !rsp.found)

endmodule

[src/kvmt_cell.sv]
// One slot of the table: holds a pair and inspects the passing request
module kvmt_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [kvmt_pkg::IDX_W-1:0]   slot_idx,
  input  kvmt_pkg::pkt_t               pkt_in,
  input  kvmt_pkg::commit_t            commit,
  output kvmt_pkg::pkt_t               pkt_out
);

  logic signed [kvmt_pkg::DATA_W-1:0] slot_key;
  logic signed [kvmt_pkg::DATA_W-1:0] slot_value;
  logic                               slot_valid;
  kvmt_pkg::pkt_t                     pkt_next;
  logic                               sel;

  assign sel = commit.en && (commit.idx == slot_idx);

  always_comb begin
    pkt_next = pkt_in;
    if (pkt_in.active) begin
      if (!pkt_in.hit && slot_valid && (slot_key == pkt_in.key)) begin
        pkt_next.hit       = 1'b1;
        pkt_next.hit_idx   = slot_idx;
        pkt_next.hit_value = slot_value;
      end
      if (!pkt_in.free_ok && !slot_valid) begin
        pkt_next.free_ok  = 1'b1;
        pkt_next.free_idx = slot_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && !commit.clr) begin
      slot_value <= commit.value;
      if (commit.set_key) begin
        slot_key <= commit.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out    <= '0;
      slot_valid <= 1'b0;
    end else begin
      pkt_out <= pkt_next;
      if (sel) begin
        if (commit.clr) begin
          slot_valid <= 1'b0;
        end else if (commit.set_key) begin
          slot_valid <= 1'b1;
        end
      end
    end
  end

endmodule

[tb/sv/tb_key_value_map_table.sv]
// Self-checking testbench for the key-value map table: directed table, then random op streams
module tb_key_value_map_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES = kvmt_pkg::TABLE_ENTRIES;
  localparam int DATA_W        = kvmt_pkg::DATA_W;
  localparam int ENTRY_W       = kvmt_pkg::ENTRY_W;
  localparam logic [1:0] FUNC_INSERT = kvmt_pkg::FUNC_INSERT;
  localparam logic [1:0] FUNC_LOOKUP = kvmt_pkg::FUNC_LOOKUP;
  localparam logic [1:0] FUNC_REMOVE = kvmt_pkg::FUNC_REMOVE;
  localparam logic [1:0] FUNC_SPARE  = 2'd3;  // unused code, behaves as lookup
  localparam int POOL_KEYS   = 100;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 80;
  localparam int DIR_ROWS    = 24;
  localparam int RING_DEPTH  = 16;

  typedef struct packed {
    kvmt_pkg::req_t item;
    logic           typed;
    kvmt_pkg::rsp_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  kvmt_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  kvmt_pkg::rsp_t rsp;

  // shadow of the map
  logic [DATA_W-1:0] slot_key [TABLE_ENTRIES];
  logic [DATA_W-1:0] slot_val [TABLE_ENTRIES];
  bit                slot_used [TABLE_ENTRIES];
  int                stored_total = 0;

  // expected results in order of acceptance
  kvmt_pkg::rsp_t    want_ring [RING_DEPTH];
  int                ring_wr = 0;
  int                ring_rd = 0;
  logic [DATA_W-1:0] key_pool [POOL_KEYS];
  row_t              dir_rows [DIR_ROWS];
  int                send_idle = 0;
  int                recv_idle = 0;
  int                mismatches = 0;
  int                stall_cycles = 0;

  key_value_map_table u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  function automatic kvmt_pkg::rsp_t apply_to_map(input kvmt_pkg::req_t r);
    kvmt_pkg::rsp_t out;
    int             hit_slot;
    int             free_at;
    out      = '0;
    hit_slot = -1;
    free_at  = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot_used[i] && slot_key[i] == r.key && hit_slot < 0) hit_slot = i;
      if (!slot_used[i] && free_at < 0) free_at = i;
    end
    if (hit_slot >= 0) begin
      out.found        = 1'b1;
      out.result_value = slot_val[hit_slot];
      if (r.func == FUNC_INSERT) begin
        slot_val[hit_slot] = r.value;
      end else if (r.func == FUNC_REMOVE) begin
        slot_used[hit_slot] = 1'b0;
        stored_total--;
      end
    end else if (r.func == FUNC_INSERT) begin
      if (free_at >= 0) begin
        slot_key[free_at]  = r.key;
        slot_val[free_at]  = r.value;
        slot_used[free_at] = 1'b1;
        stored_total++;
      end else begin
        out.full_res = 1'b1;
      end
    end
    out.entry_total = stored_total[ENTRY_W-1:0];
    out.empty_res   = (stored_total == 0);
    return out;
  endfunction

  task automatic send_item(input kvmt_pkg::req_t r, input logic typed,
                           input kvmt_pkg::rsp_t typed_rsp);
    kvmt_pkg::rsp_t want;
    while ($urandom_range(0, 99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    want = apply_to_map(r);
    want_ring[ring_wr % RING_DEPTH] = typed ? typed_rsp : want;
    ring_wr++;
  endtask

  task automatic hold_until_drained();
    req_valid <= 1'b0;
    while (ring_wr != ring_rd) @(posedge clk);
  endtask

  // fill and drain bursts over a key pool, mixed traffic, and some raw noise
  task automatic run_mix(input int n);
    int             sent;
    int             kind;
    int             len;
    int             start;
    int             pick;
    kvmt_pkg::req_t r;
    sent = 0;
    while (sent < n) begin
      kind  = $urandom_range(0, 9);
      start = $urandom_range(0, POOL_KEYS - 1);
      if (kind <= 4) len = $urandom_range(20, 72);
      else if (kind <= 8) len = $urandom_range(10, 40);
      else len = $urandom_range(3, 10);
      for (int i = 0; i < len && sent < n; i++) begin
        r.value = $urandom;
        if (kind <= 2) begin
          r.func = FUNC_INSERT;
          r.key  = key_pool[(start + i) % POOL_KEYS];
        end else if (kind <= 4) begin
          r.func = FUNC_REMOVE;
          r.key  = key_pool[(start + i) % POOL_KEYS];
        end else if (kind <= 8) begin
          pick = $urandom_range(0, 15);
          if (pick <= 6) r.func = FUNC_INSERT;
          else if (pick <= 10) r.func = FUNC_LOOKUP;
          else if (pick <= 14) r.func = FUNC_REMOVE;
          else r.func = FUNC_SPARE;
          if ($urandom_range(0, 7) == 0) r.key = $urandom;
          else r.key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
        end else begin
          r.func = 2'($urandom);
          r.key  = $urandom;
        end
        send_item(r, 1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic compare_map_reply(input kvmt_pkg::rsp_t got);
    kvmt_pkg::rsp_t want;
    if (ring_wr == ring_rd) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected item: val=%h found=%b full=%b total=%0d empty=%b",
                 got.result_value, got.found, got.full_res, got.entry_total,
                 got.empty_res);
    end else begin
      want = want_ring[ring_rd % RING_DEPTH];
      ring_rd++;
      if (got.result_value !== want.result_value || got.found !== want.found ||
          got.full_res !== want.full_res || got.entry_total !== want.entry_total ||
          got.empty_res !== want.empty_res) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want val=%h found=%b full=%b total=%0d empty=%b,",
                   want.result_value, want.found, want.full_res, want.entry_total,
                   want.empty_res,
                   " got val=%h found=%b full=%b total=%0d empty=%b",
                   got.result_value, got.found, got.full_res, got.entry_total,
                   got.empty_res);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
    if (!rst && rsp_valid === 1'b1 && rsp_ready) compare_map_reply(rsp);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid === 1'b1 && rsp_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    dir_rows = '{
      '{'{FUNC_LOOKUP, 32'h00000000, 32'h12345678}, 1'b1, '{32'h0, 1'b0, 1'b0, 7'd0, 1'b1}},
      '{'{FUNC_REMOVE, 32'h80000000, 32'hFFFFFFFF}, 1'b1, '{32'h0, 1'b0, 1'b0, 7'd0, 1'b1}},
      '{'{FUNC_SPARE,  32'h7FFFFFFF, 32'h00000000}, 1'b1, '{32'h0, 1'b0, 1'b0, 7'd0, 1'b1}},
      '{'{FUNC_INSERT, 32'h80000000, 32'h7FFFFFFF}, 1'b1, '{32'h0, 1'b0, 1'b0, 7'd1, 1'b0}},
      '{'{FUNC_INSERT, 32'h7FFFFFFF, 32'h80000000}, 1'b1, '{32'h0, 1'b0, 1'b0, 7'd2, 1'b0}},
      '{'{FUNC_LOOKUP, 32'h80000000, 32'h00000000}, 1'b1,
        '{32'h7FFFFFFF, 1'b1, 1'b0, 7'd2, 1'b0}},
      '{'{FUNC_INSERT, 32'h80000000, 32'hFFFFFFFF}, 1'b1,
        '{32'h7FFFFFFF, 1'b1, 1'b0, 7'd2, 1'b0}},
      '{'{FUNC_SPARE,  32'h80000000, 32'hAAAAAAAA}, 1'b1,
        '{32'hFFFFFFFF, 1'b1, 1'b0, 7'd2, 1'b0}},
      '{'{FUNC_INSERT, 32'h00000000, 32'h00000000}, 1'b0, '0},
      '{'{FUNC_INSERT, 32'hFFFFFFFF, 32'h55555555}, 1'b0, '0},
      '{'{FUNC_INSERT, 32'hAAAAAAAA, 32'hAAAAAAAA}, 1'b0, '0},
      '{'{FUNC_INSERT, 32'h55555555, 32'hFFFFFFFF}, 1'b0, '0},
      '{'{FUNC_LOOKUP, 32'hFFFFFFFF, 32'h00000000}, 1'b0, '0},
      '{'{FUNC_REMOVE, 32'h7FFFFFFF, 32'h00000000}, 1'b0, '0},
      '{'{FUNC_LOOKUP, 32'h7FFFFFFF, 32'h00000000}, 1'b0, '0},
      '{'{FUNC_REMOVE, 32'h7FFFFFFF, 32'h00000000}, 1'b0, '0},
      '{'{FUNC_INSERT, 32'h7FFFFFFF, 32'h00000001}, 1'b0, '0},
      '{'{FUNC_REMOVE, 32'h80000000, 32'h00000000}, 1'b0, '0},
      '{'{FUNC_REMOVE, 32'h00000000, 32'h00000000}, 1'b0, '0},
      '{'{FUNC_REMOVE, 32'hFFFFFFFF, 32'h00000000}, 1'b0, '0},
      '{'{FUNC_REMOVE, 32'hAAAAAAAA, 32'h00000000}, 1'b0, '0},
      '{'{FUNC_REMOVE, 32'h55555555, 32'h00000000}, 1'b0, '0},
      '{'{FUNC_REMOVE, 32'h7FFFFFFF, 32'h00000000}, 1'b1, '{32'h1, 1'b1, 1'b0, 7'd0, 1'b1}},
      '{'{FUNC_LOOKUP, 32'h7FFFFFFF, 32'h00000000}, 1'b1, '{32'h0, 1'b0, 1'b0, 7'd0, 1'b1}}
    };
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    key_pool[0] = 32'h80000000;
    key_pool[1] = 32'h7FFFFFFF;
    key_pool[2] = 32'h00000000;
    key_pool[3] = 32'hFFFFFFFF;
    for (int i = 4; i < POOL_KEYS; i++) key_pool[i] = $urandom;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle = 38;
    recv_idle = 65;
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    run_mix(460);
    hold_until_drained();

    send_idle = 65;
    recv_idle = 38;
    run_mix(460);
    hold_until_drained();

    send_idle = 0;
    recv_idle = 0;
    run_mix(460);
    hold_until_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
